// ----- sv/per_period_bitrate_meter_macros.svh -----
// ----------------------------------------------------------------------------
// Bitrate meter assertion macros
// Shared assertion forms for the bitrate meter.
// ----------------------------------------------------------------------------
`ifndef PER_PERIOD_BITRATE_METER_MACROS_SVH
`define PER_PERIOD_BITRATE_METER_MACROS_SVH

// implication checked every clock, disabled in reset
`define PPBM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PPBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/ppbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitrate meter package
// Widths, constants, and shared types for the bitrate meter.
// ----------------------------------------------------------------------------
`default_nettype none
package ppbm_pkg;
   localparam int WINDOW_BINS = 30;
   localparam int WIN_AW      = (WINDOW_BINS > 1) ? $clog2(WINDOW_BINS) : 1;
   localparam int CNT_W       = $clog2(WINDOW_BINS + 1);
   localparam int WSUM_W      = 46;
   localparam logic [15:0] PERIOD_RESET = 16'd1000;
   localparam logic [1:0]  ADDR_PERIOD  = 2'd0;

   typedef struct packed {
      logic [39:0] pts_ticks;
      logic signed [31:0] duration_ticks;
      logic [23:0] size_bytes;
      logic is_key;
      logic is_first;
      logic is_final;
   } req_type;

   typedef struct packed {
      logic [40:0] bin_end_time;
      logic [15:0] bar_repeat;
      logic [39:0] key_bits;
      logic [39:0] inter_bits;
      logic [39:0] smoothed_bits;
      logic [39:0] min_bin_bits;
      logic [39:0] max_bin_bits;
      logic [47:0] total_bits;
      logic run_done;
   } rsp_type;

   // close request handed to the divider
   typedef struct packed {
      logic [WSUM_W-1:0] sum;
      logic [CNT_W-1:0]  fill;
      logic [40:0]       diff;
      logic              diff_pos;
      logic [15:0]       per;
      logic [40:0]       rel;
      logic [39:0]       key_bits;
      logic [39:0]       inter_bits;
      logic [39:0]       min_bits;
      logic [39:0]       max_bits;
      logic [47:0]       total_bits;
      logic              run_done;
   } close_type;
endpackage
`default_nettype wire

// ----- sv/ppbm_if.sv -----
// ----------------------------------------------------------------------------
// Bitrate meter stream interface
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface ppbm_req_if;
   logic valid;
   logic ready;
   ppbm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ppbm_rsp_if;
   logic valid;
   logic ready;
   ppbm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/ppbm_div.sv -----
// ----------------------------------------------------------------------------
// Bitrate meter close divider
// Radix-2 restoring divider: window mean, repeat count, next start, out reg.
// ----------------------------------------------------------------------------
`default_nettype none
module ppbm_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire ppbm_pkg::close_type cls,
   output logic busy,
   output logic done,
   output logic [40:0] next_start,
   ppbm_rsp_if.source rsp
);
   localparam int STEPS = ppbm_pkg::WSUM_W;

   ppbm_pkg::close_type cls_ff;
   logic [ppbm_pkg::WSUM_W-1:0] q1_ff, r1_ff;
   logic [40:0] q2_ff, r2_ff;
   logic [40:0] q3_ff, r3_ff;
   logic [5:0] step_ff;
   logic run_ff, valid_ff;
   ppbm_pkg::rsp_type out_ff;

   logic [ppbm_pkg::WSUM_W:0] t1;
   logic [41:0] t2;
   logic [41:0] t3;
   logic [39:0] smooth;
   logic [15:0] reps;

   always_comb begin
      t1 = {r1_ff, q1_ff[ppbm_pkg::WSUM_W-1]};
      t2 = {r2_ff, q2_ff[40]};
      t3 = {r3_ff, q3_ff[40]};
      smooth = (q1_ff[ppbm_pkg::WSUM_W-1:40] != '0) ? '1 : q1_ff[39:0];
      if (!cls_ff.diff_pos) begin
         reps = 16'd1;
      end else if (q2_ff[40:16] != '0) begin
         reps = 16'hFFFF;
      end else if (q2_ff[15:0] == 16'd0) begin
         reps = 16'd1;
      end else begin
         reps = q2_ff[15:0];
      end
   end

   assign busy = run_ff || (valid_ff && !rsp.ready);
   assign rsp.valid = valid_ff;
   assign rsp.data = out_ff;
   // next bin start is the close time rounded down to a whole period
   assign done = run_ff && (step_ff == 6'(STEPS));
   assign next_start = cls_ff.rel - r3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         valid_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         if (valid_ff && rsp.ready) begin
            valid_ff <= 1'b0;
         end
         if (start) begin
            run_ff <= 1'b1;
            step_ff <= '0;
            cls_ff <= cls;
            q1_ff <= cls.sum;
            r1_ff <= '0;
            q2_ff <= cls.diff;
            r2_ff <= '0;
            q3_ff <= cls.rel;
            r3_ff <= '0;
         end else if (run_ff) begin
            if (step_ff == 6'(STEPS)) begin
               run_ff <= 1'b0;
               valid_ff <= 1'b1;
               out_ff.bin_end_time <= cls_ff.rel;
               out_ff.bar_repeat <= reps;
               out_ff.key_bits <= cls_ff.key_bits;
               out_ff.inter_bits <= cls_ff.inter_bits;
               out_ff.smoothed_bits <= smooth;
               out_ff.min_bin_bits <= cls_ff.min_bits;
               out_ff.max_bin_bits <= cls_ff.max_bits;
               out_ff.total_bits <= cls_ff.total_bits;
               out_ff.run_done <= cls_ff.run_done;
            end else begin
               step_ff <= step_ff + 6'd1;
               if (t1 >= {{(ppbm_pkg::WSUM_W+1-ppbm_pkg::CNT_W){1'b0}}, cls_ff.fill}) begin
                  r1_ff <= ppbm_pkg::WSUM_W'(t1 - {{(ppbm_pkg::WSUM_W+1-ppbm_pkg::CNT_W){1'b0}},
                     cls_ff.fill});
                  q1_ff <= {q1_ff[ppbm_pkg::WSUM_W-2:0], 1'b1};
               end else begin
                  r1_ff <= t1[ppbm_pkg::WSUM_W-1:0];
                  q1_ff <= {q1_ff[ppbm_pkg::WSUM_W-2:0], 1'b0};
               end
               if (step_ff < 6'd41) begin
                  if (t2 >= {26'd0, cls_ff.per}) begin
                     r2_ff <= 41'(t2 - {26'd0, cls_ff.per});
                     q2_ff <= {q2_ff[39:0], 1'b1};
                  end else begin
                     r2_ff <= t2[40:0];
                     q2_ff <= {q2_ff[39:0], 1'b0};
                  end
                  if (t3 >= {26'd0, cls_ff.per}) begin
                     r3_ff <= 41'(t3 - {26'd0, cls_ff.per});
                     q3_ff <= {q3_ff[39:0], 1'b1};
                  end else begin
                     r3_ff <= t3[40:0];
                     q3_ff <= {q3_ff[39:0], 1'b0};
                  end
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ----- sv/ppbm_core.sv -----
// ----------------------------------------------------------------------------
// Bitrate meter bin core
// Time keeping, bin accumulation, window memory read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none
module ppbm_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [15:0] period,
   input  wire logic div_busy,
   input  wire logic div_done,
   input  wire logic [40:0] next_start,
   output logic start,
   output ppbm_pkg::close_type cls,
   ppbm_req_if.sink req
);
   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WRITE, ST_SNAP} state_type;

   logic [39:0] win_mem [ppbm_pkg::WINDOW_BINS];
   logic [39:0] rd_ff;

   state_type state_ff;
   logic [41:0] last_ff, origin_ff;
   logic [40:0] bin_start_ff, rel_ff, diff_ff;
   logic [39:0] key_ff, inter_ff, min_ff, max_ff, tot_ff;
   logic [47:0] total_ff;
   logic [ppbm_pkg::WIN_AW-1:0] head_ff;
   logic [ppbm_pkg::CNT_W-1:0] fill_ff;
   logic [ppbm_pkg::WSUM_W-1:0] sum_ff;
   logic [15:0] per_ff;
   logic fin_ff, close_ff, start_ff, diff_pos_ff;

   logic [15:0] per;
   logic [41:0] abs_t, base_last, base_origin;
   logic [40:0] rel;
   logic [26:0] bits;
   logic [40:0] ksum, isum, bsum;
   logic [48:0] tsum;
   logic [39:0] k0, i0, key_n, inter_n;
   logic [47:0] t0, total_n;
   logic [41:0] bend;
   logic [40:0] wtot;
   logic [ppbm_pkg::WSUM_W-1:0] sum_n;

   always_comb begin
      per = (period == 16'd0) ? 16'd1 : period;
      base_last = req.data.is_first ? 42'd0 : last_ff;
      if (req.data.pts_ticks != 40'd0) begin
         abs_t = {2'b0, req.data.pts_ticks} +
            (req.data.duration_ticks[31] ? 42'd0 : {10'd0, req.data.duration_ticks});
      end else begin
         abs_t = base_last;
      end
      base_origin = req.data.is_first ? abs_t : origin_ff;
      rel = (abs_t >= base_origin) ? 41'(abs_t - base_origin) : 41'd0;
      bits = {req.data.size_bytes, 3'b000};
      k0 = (req.data.is_first || close_ff) ? 40'd0 : key_ff;
      i0 = (req.data.is_first || close_ff) ? 40'd0 : inter_ff;
      t0 = req.data.is_first ? 48'd0 : total_ff;
      ksum = {1'b0, k0} + {14'd0, bits};
      isum = {1'b0, i0} + {14'd0, bits};
      tsum = {1'b0, t0} + {22'd0, bits};
      key_n = req.data.is_key ? (ksum[40] ? '1 : ksum[39:0]) : k0;
      inter_n = req.data.is_key ? i0 : (isum[40] ? '1 : isum[39:0]);
      total_n = tsum[48] ? '1 : tsum[47:0];
      bend = {1'b0, (req.data.is_first ? 41'd0 : bin_start_ff)} + {26'd0, per};
      bsum = {1'b0, key_ff} + {1'b0, inter_ff};
      wtot = {1'b0, bsum[40] ? 40'hFF_FFFF_FFFF : bsum[39:0]};
      sum_n = sum_ff + {{(ppbm_pkg::WSUM_W-40){1'b0}}, tot_ff} -
         ((fill_ff == ppbm_pkg::CNT_W'(ppbm_pkg::WINDOW_BINS)) ?
          {{(ppbm_pkg::WSUM_W-40){1'b0}}, rd_ff} : '0);
   end

   assign req.ready = (state_ff == ST_IDLE) && !div_busy && !start_ff;
   assign start = start_ff;

   always_comb begin
      cls.sum = sum_ff;
      cls.fill = fill_ff;
      cls.diff = diff_ff;
      cls.diff_pos = diff_pos_ff;
      cls.per = per_ff;
      cls.rel = rel_ff;
      cls.key_bits = key_ff;
      cls.inter_bits = inter_ff;
      cls.min_bits = min_ff;
      cls.max_bits = max_ff;
      cls.total_bits = total_ff;
      cls.run_done = fin_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_ff <= win_mem[head_ff];
      end
      if (state_ff == ST_WRITE) begin
         win_mem[head_ff] <= tot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
         close_ff <= 1'b0;
         last_ff <= '0;
         origin_ff <= '0;
         bin_start_ff <= '0;
         key_ff <= '0;
         inter_ff <= '0;
         total_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
         head_ff <= '0;
         fill_ff <= '0;
         sum_ff <= '0;
      end else begin
         start_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (div_done) begin
                  bin_start_ff <= next_start;
               end
               if (req.valid && req.ready) begin
                  last_ff <= abs_t;
                  origin_ff <= base_origin;
                  key_ff <= key_n;
                  inter_ff <= inter_n;
                  total_ff <= total_n;
                  rel_ff <= rel;
                  per_ff <= per;
                  fin_ff <= req.data.is_final;
                  close_ff <= 1'b0;
                  if (req.data.is_first) begin
                     bin_start_ff <= '0;
                     min_ff <= '1;
                     max_ff <= '0;
                     head_ff <= '0;
                     fill_ff <= '0;
                     sum_ff <= '0;
                  end
                  if (({1'b0, rel} >= bend) || req.data.is_final) begin
                     state_ff <= ST_READ;
                     if (req.data.is_first) begin
                        diff_ff <= rel;
                        diff_pos_ff <= rel != 41'd0;
                     end else begin
                        diff_ff <= 41'(rel - bin_start_ff);
                        diff_pos_ff <= rel > bin_start_ff;
                     end
                  end
               end
            end
            ST_READ: begin
               tot_ff <= wtot[39:0];
               if (wtot[39:0] < min_ff) begin
                  min_ff <= wtot[39:0];
               end
               if (wtot[39:0] > max_ff) begin
                  max_ff <= wtot[39:0];
               end
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               sum_ff <= sum_n;
               if (fill_ff != ppbm_pkg::CNT_W'(ppbm_pkg::WINDOW_BINS)) begin
                  fill_ff <= fill_ff + ppbm_pkg::CNT_W'(1);
               end
               head_ff <= (head_ff == ppbm_pkg::WIN_AW'(ppbm_pkg::WINDOW_BINS - 1)) ?
                  '0 : head_ff + ppbm_pkg::WIN_AW'(1);
               state_ff <= ST_SNAP;
            end
            ST_SNAP: begin
               start_ff <= 1'b1;
               close_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- sv/per_period_bitrate_meter.sv -----
// An item with no result is absorbed at its accept; a bin close passes the read, write
//   and snap states and the serial divider before its result is registered.
// One item per cycle while no close runs and no result waits on rsp; a close holds the
//   input while the serial divider finds window mean, repeat count and next bin start.
// Reset: synchronous active high; period returns to 1000, all statistics clear.
// The window memory needs no clearing pass.
// ----------------------------------------------------------------------------
// Per-period bitrate meter top level
// Bins packet bits per period, reports bin statistics on rsp; period is set over APB.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_period_bitrate_meter_macros.svh"
module per_period_bitrate_meter (
   input  wire logic clock,
   input  wire logic reset,
   ppbm_req_if.sink req,
   ppbm_rsp_if.source rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [15:0] period_ff;
   logic start, busy, done;
   logic [40:0] next_start;
   ppbm_pkg::close_type cls;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ppbm_pkg::ADDR_PERIOD) ? {16'd0, period_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= ppbm_pkg::PERIOD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == ppbm_pkg::ADDR_PERIOD) begin
         period_ff <= csr_pwdata[15:0];
      end
   end

   ppbm_core u_core (
      .clock(clock), .reset(reset), .period(period_ff), .div_busy(busy),
      .div_done(done), .next_start(next_start),
      .start(start), .cls(cls), .req(req)
   );

   ppbm_div u_div (
      .clock(clock), .reset(reset), .start(start), .cls(cls), .busy(busy),
      .done(done), .next_start(next_start), .rsp(rsp)
   );

   `PPBM_ASSERT_IMP(a_no_accept_busy, clock, reset, req.ready, !busy)
   `PPBM_ASSERT_NEXT(a_start_busy, clock, reset, start, busy)
   `PPBM_ASSERT_IMP(a_rep_nonzero, clock, reset, rsp.valid, rsp.data.bar_repeat != 16'd0)
endmodule
`default_nettype wire
